// ===== rtl/box_obstacle_cell_occupancy_top_defines.svh =====
// assertion macros shared by the block's checker
`ifndef BOX_OBSTACLE_CELL_OCCUPANCY_TOP_DEFINES_SVH
`define BOX_OBSTACLE_CELL_OCCUPANCY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BOCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bocc check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BOCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bocc check failed");

`endif

// ===== rtl/bocc_pkg.sv =====
// shared types, codes and field layout of the box obstacle cell occupancy block
`timescale 1ns / 1ps

package bocc_pkg;

    // parameter defaults
    localparam int MAX_BOXES_DEF  = 16;
    localparam int INDEX_BITS_DEF = 10;

    // field widths
    localparam int COORD_W   = 16;
    localparam int EXTENT_W  = 15;
    localparam int CELL_W    = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = CELL_W + EXTENT_W;
    localparam int POINT_W   = PROD_W + 3;
    localparam int ENTRY_W   = 2 * COORD_W + 2 * EXTENT_W;

    // stream payload layout
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 8;
    localparam int STATUS_W  = 2;
    localparam int CX_LSB    = 0;
    localparam int CY_LSB    = 16;
    localparam int W_LSB     = 32;
    localparam int H_LSB     = 47;
    localparam int ROW_LSB   = 62;
    localparam int COL_LSB   = 72;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_QUERY  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 2'd2;

    // register reset values
    localparam logic [EXTENT_W-1:0]       CELL_SIZE_RST = 15'd26;
    localparam logic signed [COORD_W-1:0] ORIGIN_X_RST  = -16'sd2560;
    localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST  = -16'sd2560;

    // controller to datapath commands
    typedef struct packed {
        logic                capture;
        logic                wr_en;
        logic                load_prod;
        logic                load_point;
        logic                rd_en;
        logic                cmp_en;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } bocc_cmd_t;

endpackage

// ===== rtl/bocc_ctrl.sv =====
// controller: item sequencing, box count, scan counter and result handshake
`timescale 1ns / 1ps

module bocc_ctrl
    import bocc_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    parameter int ADDR_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int CNT_W     = $clog2(MAX_BOXES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bocc_cmd_t         cmd,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [ADDR_W-1:0] rd_addr
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_SCAN = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign wr_addr  = count_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        rd_addr      = issue_reg[ADDR_W-1:0];
        cmd          = '0;
        cmd.status   = status_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (s_tuser == CMD_LOAD)
                    begin
                        if (count_reg < CNT_W'(MAX_BOXES))
                        begin
                            cmd.wr_en   = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_STORED;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        status_next = ST_QUERY;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD:
            begin
                cmd.load_point = 1'b1;
                issue_next     = '0;
                rd_addr        = '0;
                if (count_reg != '0)
                begin
                    cmd.rd_en  = 1'b1;
                    issue_next = CNT_W'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                // compare the entry read last cycle, issue the next read while entries remain
                cmd.cmp_en = 1'b1;
                if (issue_reg < count_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            status_reg  <= ST_QUERY;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/bocc_dp.sv =====
// datapath: config registers, box memory, cell point arithmetic and edge tests
`timescale 1ns / 1ps

module bocc_dp
    import bocc_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int ADDR_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bocc_cmd_t            cmd,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int IDX_USE = (INDEX_BITS < CELL_W) ? INDEX_BITS : CELL_W;
    localparam logic [CELL_W-1:0] IDX_MASK = CELL_W'((1 << IDX_USE) - 1);

    logic [EXTENT_W-1:0]       cell_size_reg;
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;

    logic [ENTRY_W-1:0] mem [MAX_BOXES];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [CELL_W-1:0]         row_reg, col_reg;
    logic [PROD_W-1:0]         prod_x_reg, prod_y_reg;
    logic signed [POINT_W-1:0] px2_reg, py2_reg;
    logic signed [POINT_W-1:0] sum_x, sum_y;
    logic                      hit_reg;
    logic                      occupied_reg;
    logic [STATUS_W-1:0]       status_out_reg;

    logic signed [COORD_W-1:0] e_cx, e_cy;
    logic [EXTENT_W-1:0]       e_w, e_h;
    logic signed [POINT_W-1:0] cx_ext, cy_ext, cx2, cy2, w_ext, h_ext;
    logic signed [POINT_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic                      in_box;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_SIZE_RST;
            origin_x_reg  <= ORIGIN_X_RST;
            origin_y_reg  <= ORIGIN_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CELL_SIZE: cell_size_reg <= cfg_data[EXTENT_W-1:0];
                CFG_ORIGIN_X:  origin_x_reg  <= cfg_data;
                CFG_ORIGIN_Y:  origin_y_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // box memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= s_tdata[ENTRY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // cell point, doubled scale
    assign sum_x = POINT_W'(prod_x_reg) + POINT_W'(origin_x_reg);
    assign sum_y = POINT_W'(prod_y_reg) + POINT_W'(origin_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= s_tdata[ROW_LSB +: CELL_W] & IDX_MASK;
            col_reg <= s_tdata[COL_LSB +: CELL_W] & IDX_MASK;
        end
        if (cmd.load_prod)
        begin
            prod_x_reg <= PROD_W'(col_reg) * PROD_W'(cell_size_reg);
            prod_y_reg <= PROD_W'(row_reg) * PROD_W'(cell_size_reg);
        end
        if (cmd.load_point)
        begin
            px2_reg <= {sum_x[POINT_W-2:0], 1'b0};
            py2_reg <= {sum_y[POINT_W-2:0], 1'b0};
        end
    end

    // edge tests at doubled scale: left and bottom inclusive
    assign e_cx   = rdata_reg[CX_LSB +: COORD_W];
    assign e_cy   = rdata_reg[CY_LSB +: COORD_W];
    assign e_w    = rdata_reg[W_LSB +: EXTENT_W];
    assign e_h    = rdata_reg[H_LSB +: EXTENT_W];
    assign cx_ext = POINT_W'(e_cx);
    assign cy_ext = POINT_W'(e_cy);
    assign cx2    = {cx_ext[POINT_W-2:0], 1'b0};
    assign cy2    = {cy_ext[POINT_W-2:0], 1'b0};
    assign w_ext  = POINT_W'(e_w);
    assign h_ext  = POINT_W'(e_h);
    assign lo_x   = cx2 - w_ext;
    assign hi_x   = cx2 + w_ext;
    assign lo_y   = cy2 - h_ext;
    assign hi_y   = cy2 + h_ext;
    assign in_box = (lo_x <= px2_reg) && (px2_reg < hi_x)
                 && (lo_y <= py2_reg) && (py2_reg < hi_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.cmp_en && in_box)
        begin
            hit_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            occupied_reg   <= hit_reg;
            status_out_reg <= cmd.status;
        end
    end

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, occupied_reg};
    assign m_tuser = status_out_reg;

endmodule

// ===== rtl/box_obstacle_cell_occupancy_top.sv =====
// top level of the box obstacle cell occupancy block
`timescale 1ns / 1ps

// channel   | dir  | handshake          | payload
// ----------+------+--------------------+------------------------------------------
// s_        | in   | s_tvalid/s_tready  | tuser command, tdata box and cell fields
// m_        | out  | m_tvalid/m_tready  | tuser status, tdata occupied flag
// cfg_      | in   | cfg_we             | cfg_index register, cfg_data value
//
// a load goes from input transfer straight to the final step; a query multiplies, adds,
//   then scans the n stored boxes from the box memory read port one entry a cycle
// one item at a time; s_tready is high only while the controller is idle
// the result sits in an output register, so the next item is taken while it waits
// reset clears the box count and restores the register defaults; box entries are not cleared
// a stalled result holds the controller in its final step until m_tready

module box_obstacle_cell_occupancy_top
    import bocc_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // box_center_x[15:0], box_center_y[31:16], box_width[46:32],
    // box_height[61:47], cell_row[71:62], cell_col[81:72], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  logic                 s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // occupied[0], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_tuser,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);

    bocc_cmd_t         cmd;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // sequencing, box count and result valid
    bocc_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    // registers, box memory, point arithmetic, edge tests, output register
    bocc_dp #(
        .MAX_BOXES  (MAX_BOXES),
        .INDEX_BITS (INDEX_BITS),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/bocc_checker.sv =====
// port-level checker for the box obstacle cell occupancy block, with its bind
`timescale 1ns / 1ps
`include "box_obstacle_cell_occupancy_top_defines.svh"

module bocc_checker
    import bocc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // a stalled result stays offered
    `BOCC_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid)

    // one item in flight: input is closed right after a transfer
    `BOCC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // only defined status codes leave the block
    `BOCC_ASSERT_NOW(a_status_code, m_tvalid,
        m_tuser == ST_QUERY || m_tuser == ST_STORED || m_tuser == ST_FULL)

    // load results never report occupancy
    `BOCC_ASSERT_NOW(a_load_clear, m_tvalid && m_tuser != ST_QUERY, m_tdata == '0)

endmodule

bind box_obstacle_cell_occupancy_top bocc_checker u_bocc_checker (.*);
